### rtl/sstc_pkg.sv
`default_nettype none
// Shared types, constants and elaboration-time curve functions for the speed trim controller.
package sstc_pkg;

  localparam int unsigned TargetW  = 9;
  localparam int unsigned RomDepth = 1 << TargetW;

  localparam logic [63:0] Q30One = 64'd1 << 30;
  localparam logic [63:0] Ln2Q30 = 64'd744261118;

  // microstep pin codes, bit0 MS1, bit1 MS2, bit2 MS3
  localparam logic [2:0] PinsFull      = 3'b000;
  localparam logic [2:0] PinsHalf      = 3'b001;
  localparam logic [2:0] PinsQuarter   = 3'b010;
  localparam logic [2:0] PinsEighth    = 3'b011;
  localparam logic [2:0] PinsSixteenth = 3'b111;

  typedef struct packed {
    logic [2:0]  pins;
    logic [15:0] base;
  } curve_t;

  // ln(n) in Q24, n >= 1
  function automatic logic [63:0] ln_q24(input logic [63:0] n);
    logic [63:0] k;
    logic [63:0] m;
    logic [63:0] l2;
    k = '0;
    for (int i = 0; i < 31; i++) begin
      if ((n >> (i + 1)) != 64'd0) k = 64'(i + 1);
    end
    m  = (n << 30) >> k;
    l2 = k << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (Q30One << 1)) begin
        m  = m >> 1;
        l2 = l2 | (64'd1 << i);
      end
    end
    return (l2 * Ln2Q30) >> 30;
  endfunction

  // exp(-(milli/1000) ln r) in Q30, series through the sixth-power term
  function automatic logic [63:0] exp_q30(input logic [63:0] milli, input logic [63:0] lnv);
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] s;
    y = ((milli * lnv) << 6) / 64'd1000;
    t = Q30One;
    s = Q30One;
    t = (t * y) >> 30;
    s = s - t;
    t = ((t * y) >> 30) / 64'd2;
    s = s + t;
    t = ((t * y) >> 30) / 64'd3;
    s = s - t;
    t = ((t * y) >> 30) / 64'd4;
    s = s + t;
    t = ((t * y) >> 30) / 64'd5;
    s = s - t;
    t = ((t * y) >> 30) / 64'd6;
    s = s + t;
    return s;
  endfunction

  // numerator of the base width for rpm r
  function automatic logic [63:0] curve_num(input logic [63:0] r);
    logic signed [63:0] v;
    logic [63:0]        lnv;
    lnv = ln_q24(r);
    v   = '0;
    if (r > 64'd150) begin
      v = (64'sd89121 <<< 24) - 64'sd13910 * $signed(lnv);
      if (v < 0) return 64'd0;
      // 10 in Q24
      return $unsigned(v / 64'sd167772160);
    end
    if (r > 64'd75) return 64'd152215 * exp_q30(64'd4, lnv);
    if (r > 64'd35) return 64'd79504 * exp_q30(64'd17, lnv);
    if (r > 64'd19) return 64'd40254 * exp_q30(64'd24, lnv);
    return 64'd18595;
  endfunction

  // matching denominator
  function automatic logic [63:0] curve_den(input logic [63:0] r);
    if (r > 64'd150) return 64'd1;
    if (r > 64'd19) return r << 30;
    return r;
  endfunction

  function automatic logic [2:0] pins_for(input logic [TargetW-1:0] r);
    logic [2:0] p;
    priority if (r > TargetW'(150)) p = PinsFull;
    else if (r > TargetW'(75))      p = PinsHalf;
    else if (r > TargetW'(35))      p = PinsQuarter;
    else if (r > TargetW'(19))      p = PinsEighth;
    else                            p = PinsSixteenth;
    return p;
  endfunction

endpackage
`default_nettype wire

### rtl/sstc_curve_rom.sv
`default_nettype none
// Base pulse width and microstep pin table, registered read by target rpm.
module sstc_curve_rom #(
  parameter int unsigned MAX_RPM = 511
) (
  input  wire logic                         clk_i,
  input  wire logic [sstc_pkg::TargetW-1:0] addr_i,
  output sstc_pkg::curve_t                  curve_o
);

  logic [15:0] base_rom [sstc_pkg::RomDepth];
  sstc_pkg::curve_t curve_q;

  assign base_rom[0] = '0;

  for (genvar g = 1; g < sstc_pkg::RomDepth; g++) begin : g_rom
    localparam logic [63:0] Rv   = (g > MAX_RPM) ? 64'(MAX_RPM) : 64'(g);
    localparam logic [63:0] Num  = sstc_pkg::curve_num(Rv);
    localparam logic [63:0] Den  = sstc_pkg::curve_den(Rv);
    localparam logic [63:0] Base = Num / Den;
    localparam logic [63:0] Sat  = (Base > 64'd65535) ? 64'd65535 : Base;
    assign base_rom[g] = Sat[15:0];
  end

  always_ff @(posedge clk_i) begin
    curve_q.base <= base_rom[addr_i];
    curve_q.pins <= sstc_pkg::pins_for(addr_i);
  end

  assign curve_o = curve_q;

endmodule
`default_nettype wire

### rtl/stepper_speed_trim_controller_core.sv
`default_nettype none
// Stepper speed trim controller top level: step requests in, pulse width and
// speed trim out. Takes one item per clock cycle while the result register is
// empty or being taken; each item passes the input register, then the result register,
// and all controller state is read and written in the single compute stage
// between them, whose longest path is the count-to-rpm scaling multiply.
// The base width and microstep band come from a table indexed by the target
// rpm register and read into a register alongside every target write.
module stepper_speed_trim_controller_core #(
  parameter int unsigned MAX_RPM       = 511,
  parameter int unsigned WINDOW_MS     = 5000,
  parameter int unsigned EDGES_PER_REV = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [sstc_pkg::TargetW-1:0] target_rpm_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         encoder_level_i,
  input  wire logic [31:0]                  now_ms_i,
  input  wire logic                         clear_trim_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         pulse_enable_o,
  output      logic [15:0]                  pulse_width_us_o,
  output      logic [2:0]                   microstep_pins_o,
  output      logic [15:0]                  measured_rpm_o,
  output      logic                         rpm_updated_o,
  output      logic signed [15:0]           trim_value_o
);

  localparam int unsigned TW        = sstc_pkg::TargetW;
  localparam logic [63:0] RpmDiv    = 64'(EDGES_PER_REV) * 64'(WINDOW_MS);
  localparam int unsigned RpmShift  = 38;
  localparam logic [63:0] RpmMul    = ((64'd60000 << RpmShift) + RpmDiv - 64'd1) / RpmDiv;

  // configuration
  logic [TW-1:0] target_q, target_d, r_eff;
  logic          cfg_fire;
  sstc_pkg::curve_t curve;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign target_d    = cfg_fire ? target_rpm_i : target_q;
  assign r_eff       = ({1'b0, target_q} > (TW + 1)'(MAX_RPM)) ? TW'(MAX_RPM) : target_q;

  sstc_curve_rom #(
    .MAX_RPM (MAX_RPM)
  ) u_curve_rom (
    .clk_i   (clk_i),
    .addr_i  (target_d),
    .curve_o (curve)
  );

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic        s1_level_q, s1_clear_q;
  logic [31:0] s1_now_q;
  logic        in_fire, advance;

  assign advance    = s1_valid_q & (~out_valid_o | out_ready_i);
  assign in_ready_o = ~s1_valid_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;
  assign s1_valid_d = in_fire | (s1_valid_q & ~advance);

  // controller state
  logic signed [15:0] trim_q, trim_d;
  logic [15:0]        speed_q, speed_d;
  logic [15:0]        count_q, count_d;
  logic               last_level_q, last_level_d;
  logic [31:0]        window_q, window_d;
  logic [2:0]         pins_q, pins_d;

  // compute stage
  logic               active, win_close, update;
  logic signed [15:0] trim_cur, trim_new;
  logic signed [17:0] width_sum;
  logic [15:0]        width;
  logic [15:0]        count_inc;
  logic [31:0]        elapsed;
  logic [63:0]        rpm_prod;
  logic [15:0]        rpm_sat;
  logic signed [16:0] diff;
  logic signed [4:0]  delta;
  logic signed [16:0] trim_sum;

  assign active    = target_q != '0;
  assign trim_cur  = s1_clear_q ? 16'sd0 : trim_q;
  assign width_sum = $signed({2'b00, curve.base}) + $signed({{2{trim_cur[15]}}, trim_cur});

  always_comb begin
    priority if (width_sum < 18'sd0)     width = '0;
    else if (width_sum > 18'sd65535)     width = 16'hFFFF;
    else                                 width = width_sum[15:0];
  end

  assign count_inc = (s1_level_q && !last_level_q && count_q != 16'hFFFF) ?
                     count_q + 16'd1 : count_q;
  assign elapsed   = s1_now_q - window_q;
  assign win_close = elapsed > 32'(WINDOW_MS);
  assign rpm_prod  = 64'(count_inc) * 64'(RpmMul[47:0]);
  assign rpm_sat   = (rpm_prod[63:RpmShift+16] != '0) ? 16'hFFFF :
                     rpm_prod[RpmShift+15:RpmShift];
  assign update    = active & win_close & (rpm_sat != '0);

  assign diff = $signed({8'b0, r_eff}) - $signed({1'b0, speed_q});

  always_comb begin
    priority if (diff > 17'sd2)   delta = -5'sd10;
    else if (diff == 17'sd2)      delta = -5'sd3;
    else if (diff == 17'sd1)      delta = -5'sd2;
    else if (diff == -17'sd1)     delta = 5'sd2;
    else if (diff == -17'sd2)     delta = 5'sd3;
    else if (diff < -17'sd2)      delta = 5'sd10;
    else                          delta = 5'sd0;
  end

  assign trim_sum = $signed({trim_cur[15], trim_cur}) + $signed({{12{delta[4]}}, delta});
  assign trim_new = (trim_sum[16] != trim_sum[15]) ?
                    (trim_sum[16] ? 16'sh8000 : 16'sh7FFF) : trim_sum[15:0];

  always_comb begin
    trim_d       = trim_q;
    speed_d      = speed_q;
    count_d      = count_q;
    last_level_d = last_level_q;
    window_d     = window_q;
    pins_d       = pins_q;
    if (advance) begin
      trim_d = update ? trim_new : trim_cur;
      if (active) begin
        count_d      = win_close ? 16'd0 : count_inc;
        last_level_d = s1_level_q;
        pins_d       = curve.pins;
        if (win_close) window_d = s1_now_q;
        if (update) speed_d = rpm_sat;
      end
    end
  end

  // result register
  logic out_valid_q, out_valid_d;

  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      trim_q       <= '0;
      speed_q      <= '0;
      count_q      <= '0;
      last_level_q <= 1'b0;
      window_q     <= '0;
      pins_q       <= '0;
    end else begin
      target_q     <= target_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      trim_q       <= trim_d;
      speed_q      <= speed_d;
      count_q      <= count_d;
      last_level_q <= last_level_d;
      window_q     <= window_d;
      pins_q       <= pins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= encoder_level_i;
      s1_now_q   <= now_ms_i;
      s1_clear_q <= clear_trim_i;
    end
    if (advance) begin
      pulse_enable_o   <= active;
      pulse_width_us_o <= active ? width : 16'd0;
      microstep_pins_o <= active ? curve.pins : pins_q;
      measured_rpm_o   <= update ? rpm_sat : speed_q;
      rpm_updated_o    <= update;
      trim_value_o     <= update ? trim_new : trim_cur;
    end
  end

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pulse_enable_o |-> pulse_width_us_o == 16'd0 && !rpm_updated_o)
    else $error("item without pulse carries width or rpm update");

  a_update_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rpm_updated_o |-> measured_rpm_o != 16'd0)
    else $error("rpm update with zero rpm");

  a_trim_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_clear_q && !update |=> trim_q == $past(trim_q))
    else $error("trim changed without clear or window update");

endmodule
`default_nettype wire
